@@ src/swqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue table package
// Shared request and response types, item and status codes, and the
// command and status structs that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package swqt_pkg;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_REM_HEAD = 2'd1;
  localparam logic [1:0] KIND_REM_PROC = 2'd2;
  localparam logic [1:0] KIND_QUERY    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BLOCKED   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sem_key;
    logic [4:0]  proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       proc_valid;
    logic [4:0] proc_out;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_PDESC,
    OP_SETD,
    OP_RDHT,
    OP_SETHT,
    OP_RDNXT,
    OP_STEP,
    OP_UNLINK,
    OP_CLRNXT,
    OP_INS_NEW,
    OP_INS_LINK,
    OP_RSP
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] rsp_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       p_oob;
    logic       p_blocked;
    logic       scan_done;
    logic       hit;
    logic       free_found;
    logic       cur_is_tgt;
    logic       nxt_none;
  } sts_t;

endpackage

@@ src/swqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue table controller
// Sequences the key scan, the queue walk and the table updates for one item.
// ----------------------------------------------------------------------------
module swqt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  swqt_pkg::sts_t sts_i,
  output swqt_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import swqt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_PDESC,
    S_SETD,
    S_RDHT,
    S_SETHT,
    S_RDNXT,
    S_CMP,
    S_UNLINK,
    S_CLRNXT,
    S_INSNEW,
    S_INSLINK,
    S_RESP
  } state_e;

  state_e     state_q;
  logic [1:0] st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sts_i.kind == KIND_INSERT) begin
            if (sts_i.p_oob) begin
              st_q    <= ST_NOT_FOUND;
              state_q <= S_RESP;
            end else if (sts_i.p_blocked) begin
              st_q    <= ST_BLOCKED;
              state_q <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end else if (sts_i.kind == KIND_REM_PROC) begin
            if (sts_i.p_oob || !sts_i.p_blocked) begin
              st_q    <= ST_NOT_FOUND;
              state_q <= S_RESP;
            end else begin
              state_q <= S_PDESC;
            end
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            if (sts_i.hit) begin
              state_q <= S_RDHT;
            end else if (sts_i.kind == KIND_INSERT && sts_i.free_found) begin
              state_q <= S_INSNEW;
            end else begin
              st_q    <= (sts_i.kind == KIND_INSERT) ? ST_NO_FREE : ST_NOT_FOUND;
              state_q <= S_RESP;
            end
          end
        end
        S_PDESC: begin
          state_q <= S_SETD;
        end
        S_SETD: begin
          state_q <= S_RDHT;
        end
        S_RDHT: begin
          state_q <= (sts_i.kind == KIND_INSERT) ? S_INSLINK : S_SETHT;
        end
        S_SETHT: begin
          if (sts_i.kind == KIND_QUERY) begin
            st_q    <= ST_OK;
            state_q <= S_RESP;
          end else begin
            state_q <= S_RDNXT;
          end
        end
        S_RDNXT: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (sts_i.cur_is_tgt) begin
            state_q <= S_UNLINK;
          end else if (sts_i.nxt_none) begin
            st_q    <= ST_NOT_FOUND;
            state_q <= S_RESP;
          end else begin
            state_q <= S_RDNXT;
          end
        end
        S_UNLINK: begin
          state_q <= S_CLRNXT;
        end
        S_INSNEW: begin
          state_q <= S_CLRNXT;
        end
        S_INSLINK: begin
          state_q <= S_CLRNXT;
        end
        S_CLRNXT: begin
          st_q    <= ST_OK;
          state_q <= S_RESP;
        end
        S_RESP: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.rsp_status = st_q;
    case (state_q)
      S_IDLE:    cmd_o.op = start_i ? OP_LOAD : OP_NONE;
      S_SCAN:    cmd_o.op = OP_SCAN;
      S_PDESC:   cmd_o.op = OP_PDESC;
      S_SETD:    cmd_o.op = OP_SETD;
      S_RDHT:    cmd_o.op = OP_RDHT;
      S_SETHT:   cmd_o.op = OP_SETHT;
      S_RDNXT:   cmd_o.op = OP_RDNXT;
      S_CMP: begin
        cmd_o.op = (!sts_i.cur_is_tgt && !sts_i.nxt_none) ? OP_STEP : OP_NONE;
      end
      S_UNLINK:  cmd_o.op = OP_UNLINK;
      S_CLRNXT:  cmd_o.op = OP_CLRNXT;
      S_INSNEW:  cmd_o.op = OP_INS_NEW;
      S_INSLINK: cmd_o.op = OP_INS_LINK;
      S_RESP:    cmd_o.op = OP_RSP;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ src/swqt_dp.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue table datapath
// Descriptor and queue memories, the key scan pipeline, the walk registers
// and the response register.
// ----------------------------------------------------------------------------
module swqt_dp #(
  parameter int NUM_PROCS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swqt_pkg::req_t req_i,
  input  swqt_pkg::cmd_t cmd_i,
  output swqt_pkg::sts_t sts_o,
  output swqt_pkg::rsp_t rsp_o,
  output logic           done_o
);
  import swqt_pkg::*;

  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int NW = PW + 1;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam logic [NW-1:0] NONE = NW'(NUM_PROCS);

  logic [KW-1:0] key_mem   [NUM_PROCS];
  logic [PW-1:0] head_mem  [NUM_PROCS];
  logic [PW-1:0] tail_mem  [NUM_PROCS];
  logic [NW-1:0] next_mem  [NUM_PROCS];
  logic [PW-1:0] pdesc_mem [NUM_PROCS];

  logic [NUM_PROCS-1:0] active_q;
  logic [NUM_PROCS-1:0] blocked_q;

  logic [1:0]    kind_q;
  logic [KW-1:0] key_q;
  logic [4:0]    pid_q;
  logic [PW-1:0] tgt_q;
  logic [PW-1:0] d_q;
  logic [PW-1:0] free_q;
  logic [NW-1:0] prev_q;
  logic [PW-1:0] cur_q;
  logic [NW-1:0] scan_q;
  logic          cmp_vld_q;
  logic [PW-1:0] cmp_idx_q;
  logic          hit_q;
  logic          free_found_q;
  logic [KW-1:0] key_rd_q;
  logic [PW-1:0] head_rd_q;
  logic [PW-1:0] tail_rd_q;
  logic [NW-1:0] next_rd_q;
  logic [PW-1:0] pdesc_rd_q;
  rsp_t          rsp_q;
  logic          done_q;

  logic          key_match;
  logic          free_hit;
  logic          scan_live;
  logic          unl_first;
  logic          unl_free;
  logic [PW-1:0] p_idx;

  assign p_idx     = PW'(req_i.proc_id);
  assign scan_live = (cmd_i.op == OP_SCAN) && (scan_q != NONE);
  assign key_match = cmp_vld_q && !hit_q && active_q[cmp_idx_q] && (key_rd_q == key_q);
  assign free_hit  = cmp_vld_q && !free_found_q && !active_q[cmp_idx_q];
  assign unl_first = (prev_q == NONE);
  assign unl_free  = unl_first && (next_rd_q == NONE);

  // Control state: scan pipeline, occupancy flags and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      active_q     <= '0;
      blocked_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q    <= (cmd_i.op == OP_RSP);
      cmp_vld_q <= scan_live;
      if (cmd_i.op == OP_LOAD) begin
        scan_q       <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (scan_live) begin
          scan_q <= scan_q + NW'(1);
        end
        if (key_match) begin
          hit_q <= 1'b1;
        end
        if (free_hit) begin
          free_found_q <= 1'b1;
        end
      end
      case (cmd_i.op)
        OP_INS_NEW: begin
          active_q[free_q] <= 1'b1;
          blocked_q[tgt_q] <= 1'b1;
        end
        OP_INS_LINK: begin
          blocked_q[tgt_q] <= 1'b1;
        end
        OP_UNLINK: begin
          blocked_q[tgt_q] <= 1'b0;
          if (unl_free) begin
            active_q[d_q] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item registers, scan result indexes, walk registers and the response register.
  always_ff @(posedge clk_i) begin
    if (scan_live) begin
      cmp_idx_q <= scan_q[PW-1:0];
    end
    if (key_match) begin
      d_q <= cmp_idx_q;
    end
    if (free_hit) begin
      free_q <= cmp_idx_q;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q <= req_i.kind;
        key_q  <= req_i.sem_key[KW-1:0];
        pid_q  <= req_i.proc_id;
        tgt_q  <= p_idx;
      end
      OP_SETD: begin
        d_q <= pdesc_rd_q;
      end
      OP_SETHT: begin
        cur_q  <= head_rd_q;
        prev_q <= NONE;
        if (kind_q != KIND_REM_PROC) begin
          tgt_q <= head_rd_q;
        end
      end
      OP_STEP: begin
        prev_q <= {1'b0, cur_q};
        cur_q  <= next_rd_q[PW-1:0];
      end
      OP_RSP: begin
        rsp_q.status     <= cmd_i.rsp_status;
        rsp_q.proc_valid <= (cmd_i.rsp_status == ST_OK) && (kind_q != KIND_INSERT);
        rsp_q.proc_out   <= ((cmd_i.rsp_status == ST_OK) && (kind_q != KIND_INSERT))
                            ? 5'(tgt_q) : 5'd0;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (scan_live) begin
      key_rd_q <= key_mem[scan_q[PW-1:0]];
    end
    if (cmd_i.op == OP_INS_NEW) begin
      key_mem[free_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RDHT) begin
      head_rd_q <= head_mem[d_q];
      tail_rd_q <= tail_mem[d_q];
    end
    if (cmd_i.op == OP_INS_NEW) begin
      head_mem[free_q] <= tgt_q;
      tail_mem[free_q] <= tgt_q;
    end
    if (cmd_i.op == OP_INS_LINK) begin
      tail_mem[d_q] <= tgt_q;
    end
    if (cmd_i.op == OP_UNLINK) begin
      if (unl_first) begin
        head_mem[d_q] <= next_rd_q[PW-1:0];
      end
      if (tail_rd_q == tgt_q) begin
        tail_mem[d_q] <= prev_q[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RDNXT) begin
      next_rd_q <= next_mem[cur_q];
    end
    case (cmd_i.op)
      OP_INS_LINK: next_mem[tail_rd_q] <= {1'b0, tgt_q};
      OP_UNLINK: begin
        if (!unl_first) begin
          next_mem[prev_q[PW-1:0]] <= next_rd_q;
        end
      end
      OP_CLRNXT:   next_mem[tgt_q] <= NONE;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PDESC) begin
      pdesc_rd_q <= pdesc_mem[tgt_q];
    end
    if (cmd_i.op == OP_INS_NEW) begin
      pdesc_mem[tgt_q] <= free_q;
    end else if (cmd_i.op == OP_INS_LINK) begin
      pdesc_mem[tgt_q] <= d_q;
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.p_oob      = (32'(pid_q) >= NUM_PROCS);
  assign sts_o.p_blocked  = blocked_q[tgt_q];
  assign sts_o.scan_done  = hit_q || ((scan_q == NONE) && !cmp_vld_q);
  assign sts_o.hit        = hit_q;
  assign sts_o.free_found = free_found_q;
  assign sts_o.cur_is_tgt = (cur_q == tgt_q);
  assign sts_o.nxt_none   = (next_rd_q == NONE);

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

@@ src/semaphore_wait_queue_table.sv @@
// Head query and insert time is set by the key scan, which reads one descriptor key
// per cycle from the key memory. Remove head adds the head and tail read, the unlink
// and the link clear after the scan; remove given process skips the scan and walks
// the queue position by position through the next-link memory.
// One item at a time: a new item can be taken in the cycle of the done strobe.
// Reset clears all descriptors and blocked flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// Semaphore wait queue table
// Binds semaphore keys to FIFO queues of blocked process ids and serves
// insert, remove head, remove given process and head query items.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_table #(
  parameter int NUM_PROCS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  swqt_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output swqt_pkg::rsp_t rsp_o
);
  import swqt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swqt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  swqt_dp #(
    .NUM_PROCS(NUM_PROCS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

`ifndef SYNTHESIS
  // A result beat lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after start");

  // A process id only travels with a successful result.
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.proc_valid) |-> (rsp_o.status == ST_OK))
    else $error("process id with failure status");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.proc_valid) |-> (rsp_o.proc_out == 5'd0))
    else $error("nonzero process id without valid");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore wait queue table testbench
// Drives insert, remove and query items through the start/busy handshake,
// predicts every response with a behavioral copy of the queue table, and
// compares each done beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import swqt_pkg::*;

  localparam int NPROC     = 32;
  localparam int END_MARK  = NPROC;
  localparam int N_RANDOM  = 1750;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o;
  rsp_t rsp_o;

  semaphore_wait_queue_table i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0] m_key [NPROC];
  logic        m_active [NPROC];
  int          m_head [NPROC];
  int          m_tail [NPROC];
  int          m_next [NPROC];
  int          m_pdesc [NPROC];
  logic        m_blocked [NPROC];

  rsp_t rsp_queue[$];
  int   mismatch_cnt = 0;
  int   idle_pct = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic int find_key(input logic [31:0] k);
    for (int d = 0; d < NPROC; d++) if (m_active[d] && m_key[d] == k) return d;
    return NPROC;
  endfunction

  function automatic void unlink_from(input int d, input int p);
    int prev, cur, nxt;
    prev = END_MARK;
    cur = m_head[d];
    for (int s = 0; s < NPROC && cur < NPROC; s++) begin
      nxt = m_next[cur];
      if (cur == p) begin
        if (prev == END_MARK) m_head[d] = nxt;
        else m_next[prev] = nxt;
        if (m_tail[d] == p) m_tail[d] = prev;
        if (m_head[d] >= NPROC) m_active[d] = 1'b0;
        m_next[p] = END_MARK;
        return;
      end
      prev = cur;
      cur = nxt;
    end
  endfunction

  function automatic rsp_t predict_queue_op(input req_t r);
    rsp_t o;
    int d, p;
    o = '0;
    p = r.proc_id;
    case (r.kind)
      KIND_INSERT: begin
        if (m_blocked[p]) begin
          o.status = ST_BLOCKED;
        end else begin
          d = find_key(r.sem_key);
          if (d == NPROC) begin
            for (int i = NPROC - 1; i >= 0; i--) if (!m_active[i]) d = i;
            if (d == NPROC) begin
              o.status = ST_NO_FREE;
              return o;
            end
            m_active[d] = 1'b1;
            m_key[d] = r.sem_key;
            m_head[d] = p;
          end else begin
            if (m_tail[d] < NPROC) m_next[m_tail[d]] = p;
            else m_head[d] = p;
          end
          m_tail[d] = p;
          m_next[p] = END_MARK;
          m_pdesc[p] = d;
          m_blocked[p] = 1'b1;
          o.status = ST_OK;
        end
      end
      KIND_REM_PROC: begin
        if (!m_blocked[p]) begin
          o.status = ST_NOT_FOUND;
        end else begin
          unlink_from(m_pdesc[p], p);
          m_blocked[p] = 1'b0;
          o = '{ST_OK, 1'b1, r.proc_id};
        end
      end
      default: begin
        d = find_key(r.sem_key);
        if (d == NPROC || m_head[d] >= NPROC) begin
          o.status = ST_NOT_FOUND;
        end else begin
          p = m_head[d];
          if (r.kind == KIND_REM_HEAD) begin
            unlink_from(d, p);
            m_blocked[p] = 1'b0;
          end
          o = '{ST_OK, 1'b1, p[4:0]};
        end
      end
    endcase
    return o;
  endfunction

  // Predicts a typed-in row's response without touching the predictor state.
  function automatic rsp_t predict_queue_op_peek(input req_t r);
    logic [31:0] k0 [NPROC];
    logic a0 [NPROC], b0 [NPROC];
    int h0 [NPROC], t0 [NPROC], n0 [NPROC], pd0 [NPROC];
    rsp_t o;
    k0 = m_key; a0 = m_active; b0 = m_blocked;
    h0 = m_head; t0 = m_tail; n0 = m_next; pd0 = m_pdesc;
    o = predict_queue_op(r);
    m_key = k0; m_active = a0; m_blocked = b0;
    m_head = h0; m_tail = t0; m_next = n0; m_pdesc = pd0;
    return o;
  endfunction

  // Sends one item; the expected response is queued at the accepting edge.
  // Start stays high into the next item unless the sender idles first.
  task automatic send_item(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= r;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    rsp_queue.push_back(predict_queue_op(r));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_queue.size() == 0) begin
        report_mismatch("response with nothing expected");
      end else begin
        rsp_t e;
        e = rsp_queue.pop_front();
        if (rsp_o.status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", rsp_o.status, e.status));
        if (rsp_o.proc_valid !== e.proc_valid)
          report_mismatch($sformatf("proc_valid %0b exp %0b", rsp_o.proc_valid,
                                    e.proc_valid));
        if (rsp_o.proc_out !== e.proc_out)
          report_mismatch($sformatf("proc_out %0d exp %0d", rsp_o.proc_out,
                                    e.proc_out));
      end
    end
  end

  // Directed table: a typed-in expectation is checked against the predictor.
  typedef struct {
    req_t r;
    logic has_exp;
    rsp_t exp_rsp;
  } dir_row_t;

  function automatic logic [31:0] pool_key(input int i);
    return {i[7:0], 24'h5a5a00} ^ 32'h0000_00ff;
  endfunction

  function automatic req_t rand_item(input int nkeys);
    req_t r;
    int sel;
    sel = $urandom_range(99);
    r.proc_id = 5'($urandom_range(NPROC - 1));
    r.sem_key = pool_key($urandom_range(nkeys - 1));
    if (sel < 40) r.kind = KIND_INSERT;
    else if (sel < 65) r.kind = KIND_REM_HEAD;
    else if (sel < 85) r.kind = KIND_REM_PROC;
    else r.kind = KIND_QUERY;
    if ($urandom_range(19) == 0) r.sem_key = $urandom();
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    req_t r;
    rsp_t got;
    int nkeys;

    for (int i = 0; i < NPROC; i++) begin
      m_active[i] = 1'b0;
      m_blocked[i] = 1'b0;
      m_key[i] = '0; m_head[i] = 0; m_tail[i] = 0; m_next[i] = 0; m_pdesc[i] = 0;
    end

    rows.push_back('{'{KIND_QUERY, 32'h0, 5'd0}, 1, '{ST_NOT_FOUND, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_REM_HEAD, 32'hffff_ffff, 5'd0}, 1,
                     '{ST_NOT_FOUND, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_REM_PROC, 32'h0, 5'd31}, 1, '{ST_NOT_FOUND, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_INSERT, 32'hffff_ffff, 5'd31}, 1, '{ST_OK, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_INSERT, 32'hffff_ffff, 5'd31}, 1,
                     '{ST_BLOCKED, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_INSERT, 32'hffff_ffff, 5'd0}, 1, '{ST_OK, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_INSERT, 32'h0, 5'd5}, 1, '{ST_OK, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_QUERY, 32'hffff_ffff, 5'd0}, 1, '{ST_OK, 1'b1, 5'd31}});
    rows.push_back('{'{KIND_REM_HEAD, 32'hffff_ffff, 5'd0}, 1,
                     '{ST_OK, 1'b1, 5'd31}});
    rows.push_back('{'{KIND_REM_PROC, 32'h0, 5'd0}, 1, '{ST_OK, 1'b1, 5'd0}});
    rows.push_back('{'{KIND_QUERY, 32'hffff_ffff, 5'd0}, 1,
                     '{ST_NOT_FOUND, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_QUERY, 32'h0, 5'd0}, 1, '{ST_OK, 1'b1, 5'd5}});
    // Fill the pool: 31 more distinct keys, then a new key whose process is
    // already blocked.
    for (int i = 1; i < NPROC; i++)
      rows.push_back('{'{KIND_INSERT, 32'h8000_0000 | i, i[4:0] ^ 5'd5}, 0, '0});
    rows.push_back('{'{KIND_INSERT, 32'h1234_5678, 5'd5 ^ 5'd0}, 1,
                     '{ST_BLOCKED, 1'b0, 5'd0}});
    // Free two descriptors in the middle; lowest free index is reused.
    rows.push_back('{'{KIND_REM_PROC, 32'h0, 5'd7}, 0, '0});
    rows.push_back('{'{KIND_REM_PROC, 32'h0, 5'd6}, 0, '0});
    rows.push_back('{'{KIND_INSERT, 32'h1234_5678, 5'd7}, 1, '{ST_OK, 1'b0, 5'd0}});
    rows.push_back('{'{KIND_INSERT, 32'h1234_5679, 5'd6}, 1, '{ST_OK, 1'b0, 5'd0}});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        got = predict_queue_op_peek(rows[i].r);
        if (got !== rows[i].exp_rsp)
          report_mismatch($sformatf("directed row %0d predicts %h exp %h", i, got,
                                    rows[i].exp_rsp));
      end
      send_item(rows[i].r);
    end
    // Drain the directed state.
    for (int p = 0; p < NPROC; p++) send_item('{KIND_REM_PROC, 32'h0, p[4:0]});

    for (int n = 0; n < N_RANDOM; n++) begin
      case ((n * 5) / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 65;
        2: idle_pct = 12;
        3: idle_pct = 0;
        default: idle_pct = 65;
      endcase
      nkeys = (n % 400 < 200) ? 6 : 40;
      r = rand_item(nkeys);
      send_item(r);
    end
    start_i <= 1'b0;

    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000 * 12);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ semaphore_wait_queue_table.f @@
src/swqt_pkg.sv
src/swqt_ctrl.sv
src/swqt_dp.sv
src/semaphore_wait_queue_table.sv
verif/tb_top.sv
